// ===== src/txenc_pkg.sv =====
// Shared types and constants for the text encoding detector.
`timescale 1ns / 1ps

package txenc_pkg;

   // Result codes
   localparam logic [2:0] ENC_UTF8     = 3'd0;
   localparam logic [2:0] ENC_UTF8_BOM = 3'd1;
   localparam logic [2:0] ENC_UTF16LE  = 3'd2;
   localparam logic [2:0] ENC_UTF16BE  = 3'd3;
   localparam logic [2:0] ENC_GBK      = 3'd4;
   localparam logic [2:0] ENC_LATIN1   = 3'd5;

   // Byte classes and byte-order marks
   localparam logic [7:0]  GBK_LEAD_LO   = 8'h81;
   localparam logic [7:0]  GBK_HI        = 8'hFE;
   localparam logic [7:0]  GBK_TRAIL_LO  = 8'h40;
   localparam logic [7:0]  GBK_TRAIL_MID = 8'h7E;
   localparam logic [7:0]  NON_ASCII_LO  = 8'h80;
   localparam logic [7:0]  LEAD2_LO      = 8'hC0;
   localparam logic [7:0]  LEAD3_LO      = 8'hE0;
   localparam logic [7:0]  LEAD4_LO      = 8'hF0;
   localparam logic [7:0]  CONT_MASK     = 8'hC0;
   localparam logic [15:0] BOM8_HEAD     = 16'hEFBB;
   localparam logic [7:0]  BOM8_TAIL     = 8'hBF;
   localparam logic [15:0] BOM16_LE      = 16'hFFFE;
   localparam logic [15:0] BOM16_BE      = 16'hFEFF;

   // Buffer-final snapshot handed to the decision stage
   typedef struct packed {
      logic [2:0] code;      // fixed verdict when no heuristic is needed
      logic       heuristic; // choose between GBK and Latin-1
   } verdict_type;

endpackage

// ===== src/text_encoding_detector_top.sv =====
// Text encoding detector: byte stream in, one encoding code per buffer out.
//
// Usage:
//  - Input channel req_*: one byte per item (req_data_byte), req_last marks the
//    final item of a buffer, req_empty_req marks an item that carries no byte.
//    An empty item with last ends the buffer (an empty buffer gives UTF-8).
//  - Result channel rsp_*: one item with rsp_encoding per buffer, sent after
//    the item that carries req_last; 0 UTF-8, 1 UTF-8 BOM, 2 UTF-16LE,
//    3 UTF-16BE, 4 GBK, 5 Latin-1.
//  - Throughput: one item per cycle while req_stall is low. Accepting the last
//    item loads the input register, then the state update goes into the
//    snapshot register, then the GBK/Latin-1 count compare goes into the
//    result register, which drives rsp_valid.
//  - Stall: a stalled result holds. Bytes keep flowing into the state
//    registers; only a last item waits in the input register while the
//    snapshot register and a stalled result register are full; req_stall rises.
//  - Reset (synchronous) empties all stages and clears the detector state.
//  - Detector state returns to its reset values after each last item.
`timescale 1ns / 1ps

module text_encoding_detector_top #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   input  logic       req_empty_req,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_encoding
);
   import txenc_pkg::*;

   localparam int CW = COUNT_WIDTH;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff, in_empty_ff;

   // Detector state
   logic [1:0]    bytes_seen_ff, bytes_seen_in;
   logic [15:0]   leading_ff, leading_in;
   logic          bom_seen_ff, bom_seen_in;
   logic [1:0]    owed_ff, owed_in;
   logic          invalid_ff, invalid_in;
   logic          lead_pend_ff, lead_pend_in;
   logic [CW-1:0] pairs_ff, pairs_in;
   logic [CW-1:0] non_ascii_ff, non_ascii_in;

   // Snapshot register
   logic          fin_valid_ff, fin_valid_in;
   verdict_type   fin_verdict_ff, fin_verdict_in;
   logic [CW-1:0] fin_pairs_ff, fin_non_ascii_ff;

   // Result register
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_code_ff, out_code_in;

   logic out_load, fin_free, in_go, in_take;
   logic [7:0] b;
   logic       gbk_2nd;

   // Stage flow control
   always_comb begin
      out_load  = !out_valid_ff || !rsp_stall;
      fin_free  = !fin_valid_ff || out_load;
      in_go     = in_valid_ff && (!in_last_ff || fin_free);
      req_stall = in_valid_ff && in_last_ff && !fin_free;
   end

   assign in_take = req_valid && !req_stall;
   assign in_valid_in = in_take || (in_valid_ff && !in_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (in_take) begin
         in_byte_ff  <= req_data_byte;
         in_last_ff  <= req_last;
         in_empty_ff <= req_empty_req;
      end
   end

   // Per-byte state update
   assign b = in_byte_ff;
   assign gbk_2nd = ((b >= GBK_TRAIL_LO) && (b <= GBK_TRAIL_MID)) ||
                    ((b >= NON_ASCII_LO) && (b <= GBK_HI));

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      leading_in    = leading_ff;
      bom_seen_in   = bom_seen_ff;
      owed_in       = owed_ff;
      invalid_in    = invalid_ff;
      lead_pend_in  = lead_pend_ff;
      pairs_in      = pairs_ff;
      non_ascii_in  = non_ascii_ff;
      if (!in_empty_ff) begin
         // byte-order mark capture
         unique case (bytes_seen_ff)
            2'd0:    leading_in = {b, 8'h00};
            2'd1:    leading_in = {leading_ff[15:8], b};
            2'd2:    bom_seen_in = (leading_ff == BOM8_HEAD) && (b == BOM8_TAIL);
            default: ;
         endcase
         if (bytes_seen_ff != 2'd3) begin
            bytes_seen_in = bytes_seen_ff + 2'd1;
         end
         // loose UTF-8 check
         if (!invalid_ff) begin
            priority if (owed_ff != 2'd0) begin
               if ((b & CONT_MASK) == NON_ASCII_LO) begin
                  owed_in = owed_ff - 2'd1;
               end else begin
                  invalid_in = 1'b1;
               end
            end else if (b >= LEAD4_LO) begin
               owed_in = 2'd3;
            end else if (b >= LEAD3_LO) begin
               owed_in = 2'd2;
            end else if (b >= LEAD2_LO) begin
               owed_in = 2'd1;
            end else if (b >= NON_ASCII_LO) begin
               invalid_in = 1'b1;
            end else begin
               owed_in = 2'd0; // ASCII byte, nothing owed
            end
         end
         // GBK pair counting, saturating
         priority if (lead_pend_ff && gbk_2nd) begin
            if (pairs_ff != '1) begin
               pairs_in = pairs_ff + 1'b1;
            end
            lead_pend_in = 1'b0;
         end else if (b < NON_ASCII_LO) begin
            lead_pend_in = 1'b0;
         end else begin
            if (non_ascii_ff != '1) begin
               non_ascii_in = non_ascii_ff + 1'b1;
            end
            lead_pend_in = (b >= GBK_LEAD_LO) && (b <= GBK_HI);
         end
      end
   end

   // Verdict from the post-update state
   always_comb begin
      fin_verdict_in.heuristic = 1'b0;
      priority if ((bytes_seen_in == 2'd3) && bom_seen_in) begin
         fin_verdict_in.code = ENC_UTF8_BOM;
      end else if ((bytes_seen_in >= 2'd2) && (leading_in == BOM16_LE)) begin
         fin_verdict_in.code = ENC_UTF16LE;
      end else if ((bytes_seen_in >= 2'd2) && (leading_in == BOM16_BE)) begin
         fin_verdict_in.code = ENC_UTF16BE;
      end else if (bytes_seen_in == 2'd0) begin
         fin_verdict_in.code = ENC_UTF8;
      end else if (!invalid_in && (owed_in == 2'd0)) begin
         fin_verdict_in.code = ENC_UTF8;
      end else begin
         fin_verdict_in.code      = ENC_LATIN1;
         fin_verdict_in.heuristic = 1'b1;
      end
   end

   assign fin_valid_in = (in_go && in_last_ff) || (fin_valid_ff && !out_load);

   always_ff @(posedge clock) begin
      if (reset || (in_go && in_last_ff)) begin
         bytes_seen_ff <= 2'd0;
         leading_ff    <= 16'h0000;
         bom_seen_ff   <= 1'b0;
         owed_ff       <= 2'd0;
         invalid_ff    <= 1'b0;
         lead_pend_ff  <= 1'b0;
         pairs_ff      <= '0;
         non_ascii_ff  <= '0;
      end else if (in_go) begin
         bytes_seen_ff <= bytes_seen_in;
         leading_ff    <= leading_in;
         bom_seen_ff   <= bom_seen_in;
         owed_ff       <= owed_in;
         invalid_ff    <= invalid_in;
         lead_pend_ff  <= lead_pend_in;
         pairs_ff      <= pairs_in;
         non_ascii_ff  <= non_ascii_in;
      end
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
      if (in_go && in_last_ff) begin
         fin_verdict_ff   <= fin_verdict_in;
         fin_pairs_ff     <= pairs_in;
         fin_non_ascii_ff <= non_ascii_in;
      end
   end

   // GBK if 4 * pairs > non-ASCII bytes, else Latin-1
   always_comb begin
      out_code_in = fin_verdict_ff.code;
      if (fin_verdict_ff.heuristic &&
          ({fin_pairs_ff, 2'b00} > {2'b00, fin_non_ascii_ff})) begin
         out_code_in = ENC_GBK;
      end
   end

   assign out_valid_in = fin_valid_ff || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= out_valid_in;
      end
      if (out_load && fin_valid_ff) begin
         out_code_ff <= out_code_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_encoding = out_code_ff;

endmodule

// ===== src/txenc_checker.sv =====
// Port-level checks for the text encoding detector, bound to the top level.
`timescale 1ns / 1ps

module txenc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_encoding
);
   import txenc_pkg::*;

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_encoding))
      else $error("result changed while stalled");

   // Only defined codes leave the block
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_encoding <= ENC_LATIN1))
      else $error("undefined encoding code");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Input only backs up while the result side is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // A stalled input item stays offered
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("input item withdrawn while stalled");

endmodule

bind text_encoding_detector_top txenc_checker u_txenc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_encoding (rsp_encoding)
);
